### sv/urb_pkg.sv
// shared types, sizes and pointer helpers for the uart ring buffers
package urb_pkg;

	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 8;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);

	typedef logic [RX_AW-1:0] rx_ptr_t;
	typedef logic [TX_AW-1:0] tx_ptr_t;

	localparam rx_ptr_t RX_LAST = RX_AW'(RX_DEPTH - 1);
	localparam tx_ptr_t TX_LAST = TX_AW'(TX_DEPTH - 1);

	typedef enum logic [1:0] {
		KIND_RX_BYTE  = 2'd0,
		KIND_TX_EMPTY = 2'd1,
		KIND_PUT      = 2'd2,
		KIND_GET      = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       frame_error;
		logic       overrun_error;
		logic       parity_error;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_valid;
		logic        accepted;
		logic        rx_irq_enable;
		logic        tx_irq_enable;
		logic        rx_available;
		logic        tx_has_room;
		logic [15:0] frame_errors;
		logic [15:0] overrun_errors;
		logic [15:0] parity_errors;
		logic [15:0] received_total;
		logic [15:0] sent_total;
	} out_item_t;

	function automatic rx_ptr_t rx_adv(input rx_ptr_t p);
		return (p == RX_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic tx_ptr_t tx_adv(input tx_ptr_t p);
		return (p == TX_LAST) ? '0 : p + 1'b1;
	endfunction

endpackage

### sv/urb_in_if.sv
// event channel into the ring buffer block
interface urb_in_if;
	logic               valid;
	logic               ready;
	urb_pkg::in_item_t  item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### sv/urb_out_if.sv
// result channel out of the ring buffer block
interface urb_out_if;
	logic               valid;
	logic               ready;
	urb_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### sv/urb_ram.sv
// simple dual port ram, one write port and one registered read port
module urb_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/uart_rx_tx_ring_buffers_core.sv
// uart receive and transmit ring buffers with error and byte counters
// pointers and counters update when an event is accepted, the ring memories are
// read in that same cycle and the byte appears in the result word in the following
// cycle, registered in the ram read port.
// sustained rate is one event per clock while the result side keeps taking words.
// reset clears pointers, counters and tx enable, sets rx enable; ring contents stay.
module uart_rx_tx_ring_buffers_core (
	input  logic             clk,
	input  logic             arst_n,
	urb_in_if.sink           evt,
	urb_out_if.source        res
);
	import urb_pkg::*;

	rx_ptr_t     rx_wp_q, rx_rp_q, rx_wp_d, rx_rp_d;
	tx_ptr_t     tx_wp_q, tx_rp_q, tx_wp_d, tx_rp_d;
	logic        rx_int_en_q, rx_int_en_d;
	logic        tx_int_en_q, tx_int_en_d;
	logic [15:0] frame_cnt_q, overrun_cnt_q, parity_cnt_q, recv_cnt_q, sent_cnt_q;
	logic [15:0] frame_cnt_d, overrun_cnt_d, parity_cnt_d, recv_cnt_d, sent_cnt_d;

	logic        valid_s1, ovalid_s1, acc_s1, tx_src_s1;
	logic        ovalid_d, acc_d, tx_src_d;

	logic        fire;
	logic        rx_we, rx_re, tx_we, tx_re;
	logic        rx_full, rx_empty, tx_full, tx_empty, any_err;
	logic [7:0]  rx_rdata, tx_rdata;

	assign fire = evt.valid && evt.ready;
	assign evt.ready = !valid_s1 || res.ready;

	assign rx_full  = rx_adv(rx_wp_q) == rx_rp_q;
	assign rx_empty = rx_wp_q == rx_rp_q;
	assign tx_full  = tx_adv(tx_wp_q) == tx_rp_q;
	assign tx_empty = tx_wp_q == tx_rp_q;
	assign any_err  = evt.item.frame_error || evt.item.overrun_error || evt.item.parity_error;

	always_comb begin
		rx_wp_d       = rx_wp_q;
		rx_rp_d       = rx_rp_q;
		tx_wp_d       = tx_wp_q;
		tx_rp_d       = tx_rp_q;
		rx_int_en_d   = rx_int_en_q;
		tx_int_en_d   = tx_int_en_q;
		frame_cnt_d   = frame_cnt_q;
		overrun_cnt_d = overrun_cnt_q;
		parity_cnt_d  = parity_cnt_q;
		recv_cnt_d    = recv_cnt_q;
		sent_cnt_d    = sent_cnt_q;
		ovalid_d      = 1'b0;
		acc_d         = 1'b0;
		tx_src_d      = 1'b0;
		rx_we         = 1'b0;
		rx_re         = 1'b0;
		tx_we         = 1'b0;
		tx_re         = 1'b0;
		unique case (evt.item.kind)
			KIND_RX_BYTE: begin
				if (any_err) begin
					if (evt.item.frame_error) frame_cnt_d = frame_cnt_q + 16'd1;
					if (evt.item.overrun_error) overrun_cnt_d = overrun_cnt_q + 16'd1;
					if (evt.item.parity_error) parity_cnt_d = parity_cnt_q + 16'd1;
				end else if (rx_full) begin
					rx_int_en_d = 1'b0;
				end else begin
					rx_we      = fire;
					rx_wp_d    = rx_adv(rx_wp_q);
					recv_cnt_d = recv_cnt_q + 16'd1;
					acc_d      = 1'b1;
				end
			end
			KIND_TX_EMPTY: begin
				if (tx_empty) begin
					tx_int_en_d = 1'b0;
				end else begin
					tx_re      = fire;
					tx_rp_d    = tx_adv(tx_rp_q);
					sent_cnt_d = sent_cnt_q + 16'd1;
					ovalid_d   = 1'b1;
					tx_src_d   = 1'b1;
				end
			end
			KIND_PUT: begin
				if (!tx_full) begin
					tx_we       = fire;
					tx_wp_d     = tx_adv(tx_wp_q);
					tx_int_en_d = 1'b1;
					acc_d       = 1'b1;
				end
			end
			KIND_GET: begin
				if (!rx_empty) begin
					rx_re       = fire;
					rx_rp_d     = rx_adv(rx_rp_q);
					rx_int_en_d = 1'b1;
					ovalid_d    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// state registers change only when an event is taken, so the result word
	// can show them directly while it waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wp_q       <= '0;
			rx_rp_q       <= '0;
			tx_wp_q       <= '0;
			tx_rp_q       <= '0;
			rx_int_en_q   <= 1'b1;
			tx_int_en_q   <= 1'b0;
			frame_cnt_q   <= '0;
			overrun_cnt_q <= '0;
			parity_cnt_q  <= '0;
			recv_cnt_q    <= '0;
			sent_cnt_q    <= '0;
			valid_s1      <= 1'b0;
			ovalid_s1     <= 1'b0;
			acc_s1        <= 1'b0;
			tx_src_s1     <= 1'b0;
		end else begin
			if (fire) begin
				rx_wp_q       <= rx_wp_d;
				rx_rp_q       <= rx_rp_d;
				tx_wp_q       <= tx_wp_d;
				tx_rp_q       <= tx_rp_d;
				rx_int_en_q   <= rx_int_en_d;
				tx_int_en_q   <= tx_int_en_d;
				frame_cnt_q   <= frame_cnt_d;
				overrun_cnt_q <= overrun_cnt_d;
				parity_cnt_q  <= parity_cnt_d;
				recv_cnt_q    <= recv_cnt_d;
				sent_cnt_q    <= sent_cnt_d;
				ovalid_s1     <= ovalid_d;
				acc_s1        <= acc_d;
				tx_src_s1     <= tx_src_d;
			end
			if (fire) begin
				valid_s1 <= 1'b1;
			end else if (res.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	urb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_wp_q),
		.wdata (evt.item.data),
		.re    (rx_re),
		.raddr (rx_rp_q),
		.rdata (rx_rdata)
	);

	urb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_wp_q),
		.wdata (evt.item.data),
		.re    (tx_re),
		.raddr (tx_rp_q),
		.rdata (tx_rdata)
	);

	assign res.valid = valid_s1;

	always_comb begin
		res.item                = '0;
		res.item.out_byte       = !ovalid_s1 ? 8'd0 : (tx_src_s1 ? tx_rdata : rx_rdata);
		res.item.out_valid      = ovalid_s1;
		res.item.accepted       = acc_s1;
		res.item.rx_irq_enable  = rx_int_en_q;
		res.item.tx_irq_enable  = tx_int_en_q;
		res.item.rx_available   = !(rx_wp_q == rx_rp_q);
		res.item.tx_has_room    = !(tx_adv(tx_wp_q) == tx_rp_q);
		res.item.frame_errors   = frame_cnt_q;
		res.item.overrun_errors = overrun_cnt_q;
		res.item.parity_errors  = parity_cnt_q;
		res.item.received_total = recv_cnt_q;
		res.item.sent_total     = sent_cnt_q;
	end

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !evt.ready)
		else $error("event taken while result word is stalled");

	a_put_sets_tx_en: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evt.item.kind == KIND_PUT && !tx_full |=> tx_int_en_q && res.item.accepted)
		else $error("put into non-full ring did not set tx enable");

	a_full_rx_refused: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evt.item.kind == KIND_RX_BYTE && !any_err && rx_full
		|=> !rx_int_en_q && $stable(rx_wp_q) && !res.item.accepted)
		else $error("receive into full ring was not refused");

	a_get_moves_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evt.item.kind == KIND_GET && !rx_empty
		|=> rx_rp_q != $past(rx_rp_q) && res.item.out_valid)
		else $error("get from non-empty ring did not advance read pointer");

endmodule

### sim/tb_uart_rx_tx_ring_buffers_core.sv
// self-checking testbench for the uart ring buffer core: random events, predicted result words
module tb_uart_rx_tx_ring_buffers_core;
	timeunit 1ns;
	timeprecision 1ps;

	import urb_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_AFTER_WORDS = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int STEADY_ROUNDS = 100;
	localparam int RANDOM_HALF = 500;

	// tracks both rings, enables and counters, and queues the word each event should produce
	class ring_tracker;
		logic [7:0]  rx_ring [RX_DEPTH];
		logic [7:0]  tx_ring [TX_DEPTH];
		rx_ptr_t     rx_wr, rx_rd;
		tx_ptr_t     tx_wr, tx_rd;
		logic        rx_ie, tx_ie;
		logic [15:0] n_frame, n_overrun, n_parity, n_received, n_sent;
		out_item_t   expected_words [$];
		int          errors;
		int          checked;

		function new();
			rx_wr = '0;
			rx_rd = '0;
			tx_wr = '0;
			tx_rd = '0;
			rx_ie = 1'b1;
			tx_ie = 1'b0;
			n_frame = '0;
			n_overrun = '0;
			n_parity = '0;
			n_received = '0;
			n_sent = '0;
			errors = 0;
			checked = 0;
		endfunction

		function rx_ptr_t rx_next(rx_ptr_t p);
			return rx_ptr_t'((int'(p) + 1) % RX_DEPTH);
		endfunction

		function tx_ptr_t tx_next(tx_ptr_t p);
			return tx_ptr_t'((int'(p) + 1) % TX_DEPTH);
		endfunction

		function void take_event(in_item_t ev);
			out_item_t w;
			w = '0;
			case (ev.kind)
				KIND_RX_BYTE: begin
					if (ev.frame_error || ev.overrun_error || ev.parity_error) begin
						// errored byte is dropped, only its error counters move
						if (ev.frame_error) n_frame++;
						if (ev.overrun_error) n_overrun++;
						if (ev.parity_error) n_parity++;
					end else if (rx_next(rx_wr) == rx_rd) begin
						rx_ie = 1'b0;
					end else begin
						rx_ring[rx_wr] = ev.data;
						rx_wr = rx_next(rx_wr);
						n_received++;
						w.accepted = 1'b1;
					end
				end
				KIND_TX_EMPTY: begin
					if (tx_wr == tx_rd) begin
						tx_ie = 1'b0;
					end else begin
						w.out_byte = tx_ring[tx_rd];
						w.out_valid = 1'b1;
						tx_rd = tx_next(tx_rd);
						n_sent++;
					end
				end
				KIND_PUT: begin
					if (tx_next(tx_wr) != tx_rd) begin
						tx_ring[tx_wr] = ev.data;
						tx_wr = tx_next(tx_wr);
						tx_ie = 1'b1;
						w.accepted = 1'b1;
					end
				end
				KIND_GET: begin
					if (rx_wr != rx_rd) begin
						w.out_byte = rx_ring[rx_rd];
						w.out_valid = 1'b1;
						rx_rd = rx_next(rx_rd);
						rx_ie = 1'b1;
					end
				end
			endcase
			w.rx_irq_enable = rx_ie;
			w.tx_irq_enable = tx_ie;
			w.rx_available = (rx_wr != rx_rd);
			w.tx_has_room = (tx_next(tx_wr) != tx_rd);
			w.frame_errors = n_frame;
			w.overrun_errors = n_overrun;
			w.parity_errors = n_parity;
			w.received_total = n_received;
			w.sent_total = n_sent;
			expected_words.push_back(w);
		endfunction

		function void cmp(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void match_word(out_item_t got);
			out_item_t want;
			if (expected_words.size() == 0) begin
				$error("result word with no event pending: %h", got);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			checked++;
			cmp("out_byte", 16'(want.out_byte), 16'(got.out_byte));
			cmp("out_valid", 16'(want.out_valid), 16'(got.out_valid));
			cmp("accepted", 16'(want.accepted), 16'(got.accepted));
			cmp("rx_irq_enable", 16'(want.rx_irq_enable), 16'(got.rx_irq_enable));
			cmp("tx_irq_enable", 16'(want.tx_irq_enable), 16'(got.tx_irq_enable));
			cmp("rx_available", 16'(want.rx_available), 16'(got.rx_available));
			cmp("tx_has_room", 16'(want.tx_has_room), 16'(got.tx_has_room));
			cmp("frame_errors", want.frame_errors, got.frame_errors);
			cmp("overrun_errors", want.overrun_errors, got.overrun_errors);
			cmp("parity_errors", want.parity_errors, got.parity_errors);
			cmp("received_total", want.received_total, got.received_total);
			cmp("sent_total", want.sent_total, got.sent_total);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	urb_in_if  evt_ch ();
	urb_out_if res_ch ();

	uart_rx_tx_ring_buffers_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch.sink),
		.res    (res_ch.source)
	);

	ring_tracker tracker = new();
	bit steady = 1'b0;
	int events_in = 0;
	int words_out = 0;
	int stall_cycles = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic send_event(input kind_t k, input logic [7:0] d, input logic [2:0] flags);
		in_item_t ev;
		ev.kind = k;
		ev.data = d;
		ev.frame_error = flags[2];
		ev.overrun_error = flags[1];
		ev.parity_error = flags[0];
		if (!steady) begin
			while ($urandom_range(99) < 23) begin
				evt_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		evt_ch.valid <= 1'b1;
		evt_ch.item <= ev;
		do @(posedge clk); while (!evt_ch.ready);
		tracker.take_event(ev);
		events_in++;
	endtask

	function automatic kind_t pick_kind(int mode);
		kind_t favored;
		case (mode)
			0: favored = KIND_RX_BYTE;
			1: favored = KIND_GET;
			2: favored = KIND_PUT;
			default: favored = KIND_TX_EMPTY;
		endcase
		if (mode < 4 && $urandom_range(99) < 75)
			return favored;
		return kind_t'($urandom_range(3));
	endfunction

	// most bursts lean toward filling or draining one ring so full and empty edges get hit often
	task automatic random_events(input int count);
		int n;
		int mode;
		int burst;
		kind_t k;
		logic [2:0] flags;
		n = 0;
		while (n < count) begin
			mode = $urandom_range(4);
			burst = $urandom_range(20, 60);
			repeat (burst) begin
				k = pick_kind(mode);
				if (k == KIND_RX_BYTE)
					flags = ($urandom_range(99) < 15) ? 3'($urandom_range(7, 1)) : 3'b000;
				else
					flags = 3'($urandom_range(7));
				send_event(k, 8'($urandom_range(255)), flags);
				n++;
			end
		end
	endtask

	initial begin : stimulus
		evt_ch.valid = 1'b0;
		evt_ch.item = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty rings, then each error flag alone and together
		send_event(KIND_TX_EMPTY, 8'h00, 3'b000);
		send_event(KIND_GET, 8'hff, 3'b111);
		send_event(KIND_RX_BYTE, 8'hff, 3'b100);
		send_event(KIND_RX_BYTE, 8'hff, 3'b010);
		send_event(KIND_RX_BYTE, 8'hff, 3'b001);
		send_event(KIND_RX_BYTE, 8'h00, 3'b111);
		send_event(KIND_RX_BYTE, 8'h00, 3'b000);
		send_event(KIND_RX_BYTE, 8'hff, 3'b000);
		send_event(KIND_RX_BYTE, 8'h5a, 3'b000);
		repeat (3) send_event(KIND_GET, 8'h00, 3'b000);
		send_event(KIND_PUT, 8'h00, 3'b000);
		send_event(KIND_PUT, 8'hff, 3'b000);
		repeat (2) send_event(KIND_TX_EMPTY, 8'h00, 3'b000);
		// fill the transmit ring, last put is refused
		for (int i = 0; i < TX_DEPTH; i++)
			send_event(KIND_PUT, 8'ha5 ^ 8'(i), 3'b000);
		send_event(KIND_TX_EMPTY, 8'h00, 3'b000);

		random_events(RANDOM_HALF);

		// back to back stretch with no idling on either side
		steady = 1'b1;
		repeat (STEADY_ROUNDS) begin
			send_event(KIND_RX_BYTE, 8'($urandom_range(255)), 3'b111);
			send_event(KIND_RX_BYTE, 8'($urandom_range(255)), 3'b000);
			send_event(KIND_GET, 8'($urandom_range(255)), 3'b000);
			send_event(KIND_PUT, 8'($urandom_range(255)), 3'b000);
			send_event(KIND_TX_EMPTY, 8'($urandom_range(255)), 3'b000);
		end
		steady = 1'b0;

		random_events(RANDOM_HALF);
		evt_ch.valid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("%0d events sent, %0d result words checked", events_in, tracker.checked);
		$display("covered full and empty rings, errored receives, result back-pressure, gapless runs");
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("tb_uart_rx_tx_ring_buffers_core: done, clean");
		end else begin
			$display("tb_uart_rx_tx_ring_buffers_core: done, errors");
		end
		$finish;
	end

	initial begin : result_sink
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				tracker.match_word(res_ch.item);
				words_out++;
			end
			// one long hold-off so the block backs up and stalls its input
			if (!held && words_out == HOLD_AFTER_WORDS) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("tb_uart_rx_tx_ring_buffers_core: done, errors");
				$finish;
			end
		end
	end

endmodule

### filelist.f
sv/urb_pkg.sv
sv/urb_in_if.sv
sv/urb_out_if.sv
sv/urb_ram.sv
sv/uart_rx_tx_ring_buffers_core.sv
sim/tb_uart_rx_tx_ring_buffers_core.sv
